[hw/rtl/sha512_pkg.sv]
// sha512_pkg: shared constants, types and round functions for the sha-512 hasher
// no dependencies
`timescale 1ns / 1ps
package sha512_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUND_COUNT = 80;
   localparam int DIGEST_WORDS = 8;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   // control from the sequencer to the compression unit
   typedef struct packed {
      logic start;
      logic reload;
   } core_ctrl_type;

   localparam word_type ROUND_CONST [ROUND_COUNT] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam word_type INITIAL_HASH [DIGEST_WORDS] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WORD_WIDTH - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

[hw/rtl/sha512_message_hasher_top.sv]
// sha512_message_hasher_top: message buffering, padding and digest output for sha-512
// depends on sha512_pkg and sha512_core
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_message_word, req_byte_count, req_last_word
//   rsp     | out       | rsp_valid, rsp_stall, rsp_digest_word, rsp_word_index, rsp_last_result
//
// a non-final word that fills the block stalls the input while the block is compressed:
// a start step, 80 rounds, a finishing step and an update step; other non-final words
// are taken without a stall. a final word adds padding words, one per cycle, and one or two
// blocks of compression, then eight digest transactions.
// one round per cycle in the shared round unit sets the block time.
// reset is synchronous and reloads the initial hash; rsp_stall only holds the output.
`timescale 1ns / 1ps
module sha512_message_hasher_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sha512_pkg::word_type   req_message_word,
   input  logic [3:0]             req_byte_count,
   input  logic                   req_last_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sha512_pkg::word_type   rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_last_result
);
   import sha512_pkg::*;

   state_type     state_ff, state_in;
   word_type      buf_ff [BLOCK_WORDS];
   logic [3:0]    fill_ff, fill_in;
   logic [63:0]   len_ff, len_in;
   logic          padded_ff, padded_in;   // 0x80 marker already placed
   logic [2:0]    out_idx_ff, out_idx_in;
   logic          final_ff, final_in;     // current compression closes the message
   logic          closing_ff, closing_in; // last word taken, message still being padded
   core_ctrl_type ctrl;
   logic          core_done;
   word_type      hash [DIGEST_WORDS];

   logic          accept;
   logic          wr_en;
   word_type      wr_data;
   logic [3:0]    cnt;
   word_type      keep;

   sha512_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .block (buf_ff),
      .done  (core_done),
      .hash  (hash)
   );

   assign accept = req_valid && !req_stall;
   assign cnt = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
   assign keep = ~({WORD_WIDTH{1'b1}} >> {cnt, 3'b000});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (fill_ff == 4'(BLOCK_WORDS - 1)) state_in = ST_INIT;
               else if (req_last_word) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (!padded_ff && fill_ff == 4'(BLOCK_WORDS - 1)) state_in = ST_INIT;
            else if (padded_ff && fill_ff == 4'(BLOCK_WORDS - 1)) state_in = ST_INIT;
         end
         ST_INIT:   state_in = ST_ROUND;
         ST_ROUND:  if (core_done) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (final_ff) state_in = ST_OUTPUT;
            else if (closing_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_OUTPUT: if (!rsp_stall && out_idx_ff == 3'(DIGEST_WORDS - 1)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      ctrl.start = (state_ff == ST_INIT);
      ctrl.reload = (state_ff == ST_OUTPUT) && !rsp_stall &&
                    (out_idx_ff == 3'(DIGEST_WORDS - 1));
      rsp_valid       = (state_ff == ST_OUTPUT);
      rsp_digest_word = hash[out_idx_ff];
      rsp_word_index  = out_idx_ff;
      rsp_last_result = (out_idx_ff == 3'(DIGEST_WORDS - 1));

      fill_in    = fill_ff;
      len_in     = len_ff;
      padded_in  = padded_ff;
      out_idx_in = out_idx_ff;
      final_in   = final_ff;
      closing_in = closing_ff;
      wr_en      = 1'b0;
      wr_data    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (!req_last_word) begin
                  wr_data = req_message_word;
                  len_in  = len_ff + 64'd64;
               end else begin
                  closing_in = 1'b1;
                  len_in = len_ff + {57'd0, cnt, 3'b000};
                  if (cnt == 4'd8) begin
                     wr_data   = req_message_word;
                     padded_in = 1'b0;
                  end else begin
                     wr_data = (req_message_word & keep) |
                               ({56'd0, PAD_BYTE} << (7'd56 - {cnt, 3'b000}));
                     padded_in = 1'b1;
                  end
               end
            end
         end
         ST_PAD: begin
            // one word per cycle: marker if not yet placed, zeros, then length in word 15 of the final block
            wr_en   = 1'b1;
            fill_in = fill_ff + 4'd1;
            if (!padded_ff) begin
               wr_data   = {PAD_BYTE, 56'd0};
               padded_in = 1'b1;
            end else if (fill_ff == 4'(BLOCK_WORDS - 1) && final_ff) begin
               wr_data = len_ff;
            end else begin
               wr_data = '0;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  len_in     = '0;
                  padded_in  = 1'b0;
                  final_in   = 1'b0;
                  closing_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      // room for the length decides whether this pad block is the final one
      if (state_ff == ST_PAD || (state_ff == ST_IDLE && accept && req_last_word)) begin
         if (padded_in && fill_in >= 4'd1 && fill_in <= 4'd14)
            final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_ff[fill_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         len_ff     <= '0;
         padded_ff  <= 1'b0;
         out_idx_ff <= '0;
         final_ff   <= 1'b0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         padded_ff  <= padded_in;
         out_idx_ff <= out_idx_in;
         final_ff   <= final_in;
         closing_ff <= closing_in;
      end
   end

endmodule

[hw/rtl/sha512_core.sv]
// sha512_core: one sha-512 round per cycle over a 16-word rolling schedule
// depends on sha512_pkg
`timescale 1ns / 1ps
module sha512_core (
   input  logic                          clock,
   input  logic                          reset,
   input  sha512_pkg::core_ctrl_type     ctrl,
   input  sha512_pkg::word_type          block [sha512_pkg::BLOCK_WORDS],
   output logic                          done,
   output sha512_pkg::word_type          hash [sha512_pkg::DIGEST_WORDS]
);
   import sha512_pkg::*;

   word_type  sched_ff [BLOCK_WORDS];
   word_type  var_ff [DIGEST_WORDS];
   word_type  hash_ff [DIGEST_WORDS];
   logic [6:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       upd_ff, upd_in;

   word_type choose, major, t1, t2, w_next;

   assign hash = hash_ff;
   assign done = upd_ff;

   always_comb begin
      choose = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      major  = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t1 = var_ff[7] + big_sigma1(var_ff[4]) + choose + ROUND_CONST[round_ff] + sched_ff[0];
      t2 = big_sigma0(var_ff[0]) + major;
      w_next = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1]) + sched_ff[0];
   end

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      upd_in   = 1'b0;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
      end else if (busy_ff) begin
         round_in = round_ff + 7'd1;
         if (round_ff == 7'(ROUND_COUNT - 1)) begin
            busy_in  = 1'b0;
            upd_in   = 1'b1;
            round_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         upd_ff   <= 1'b0;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         upd_ff   <= upd_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.reload) begin
         hash_ff <= INITIAL_HASH;
      end else if (upd_ff) begin
         for (int i = 0; i < DIGEST_WORDS; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         sched_ff <= block;
         var_ff   <= hash_ff;
      end else if (busy_ff) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[BLOCK_WORDS-1] <= w_next;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

endmodule
